FILE: sv/i2cm_pkg.sv
// Shared types and constants of the I2C master controller.
`default_nettype none

package i2cm_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned SHIFT_W = 19;

    localparam logic [10:0] TX_FILL   = 11'h7FF;
    localparam logic [2:0]  BIT_START = 3'd7;

    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } t_req;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_START       = 4'd1,
        PH_HEADER      = 4'd2,
        PH_ACK_HEADER  = 4'd3,
        PH_RX          = 4'd4,
        PH_ACK_RX      = 4'd5,
        PH_TX          = 4'd6,
        PH_WAIT_ACK_TX = 4'd7,
        PH_STOP        = 4'd8
    } t_phase;

    localparam logic [INDEX_W-1:0] REG_DIVIDER = 10'd0;
    localparam logic [INDEX_W-1:0] REG_STATUS  = 10'd1;
    localparam logic [INDEX_W-1:0] REG_ADDRESS = 10'd2;
    localparam logic [INDEX_W-1:0] REG_PAYLOAD = 10'd3;

    localparam logic CFG_DIVIDER = 1'b0;
    localparam logic CFG_SETUP   = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [INDEX_W-1:0] reg_index;
        logic [DATA_W-1:0]  write_data;
        logic               sda_in;
    } t_in_word;

    typedef struct packed {
        logic              answered;
        logic [DATA_W-1:0] read_data;
        logic              scl_out;
        logic              sda_out;
        logic              sda_is_input;
        logic              irq_out;
        logic              device_reset_out;
    } t_out_word;

endpackage

`default_nettype wire

FILE: sv/i2cm_in_if.sv
// Input channel interface of the I2C master controller.
`default_nettype none

interface i2cm_in_if
    import i2cm_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/i2cm_out_if.sv
// Result channel interface of the I2C master controller.
`default_nettype none

interface i2cm_out_if
    import i2cm_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/i2c_master_controller.sv
// Top level of the I2C master controller: bus state machine and register file.
`default_nettype none

// The block is an I2C master that advances by one tick for every word taken
// on the input channel. A word carries an optional register access (read or
// write at a register index) and the sampled SDA level. For every input word
// exactly one result word comes out: the access response and read data, plus
// the SCL, SDA, SDA direction, interrupt and device reset levels after the tick.
// The user must write the clock divider and setup point through the
// configuration port only while the block is idle; the block itself does not
// enforce this. A write also restarts the tick counter. The state update and
// the result are computed in the cycle a word is accepted, and the result word
// sits in the output register on the next cycle. Throughput is one word per
// cycle, limited only by the single output register: input ready is high
// whenever that register is empty or is being drained in the same cycle.
// When the receiver stalls, the result word holds and input ready drops until
// it is taken; no word is dropped and the bus state does not advance.
// Synchronous active-low reset puts the bus machine in idle with SCL and SDA
// high, clears all flags and errors and empties the output register.
module i2c_master_controller
    import i2cm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    i2cm_in_if.sink               i_in,
    i2cm_out_if.source            o_out
);

    // Configuration registers.
    logic [CFG_W-1:0] r_div;
    logic [CFG_W-1:0] r_setup;

    // Bus and register state.
    logic [CFG_W-1:0]   r_tick,  n_tick;
    logic               r_level, n_level;
    t_phase             r_phase, n_phase;
    logic               r_start, n_start;
    logic [6:0]         r_addr,  n_addr;
    logic               r_rnw,   n_rnw;
    logic [DATA_W-1:0]  r_pay,   n_pay;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic [7:0]         r_rx,    n_rx;
    logic [2:0]         r_bit,   n_bit;
    logic [3:0]         r_byte,  n_byte;
    logic               r_ack,   n_ack;
    logic               r_eh,    n_eh;
    logic               r_ed,    n_ed;
    logic               r_irq,   n_irq;
    logic               r_ie,    n_ie;
    logic               r_rst,   n_rst;
    logic               r_dir,   n_dir;

    // Output register.
    logic      r_out_valid;
    t_out_word r_out;

    logic              in_acc;
    logic              chg;
    logic              lat;
    logic              acc_valid;
    logic              acc_wr;
    logic [DATA_W-1:0] rd;
    t_in_word          w;

    assign w         = i_in.data;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc    = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign acc_valid = (w.req_type == REQ_READ) || (w.req_type == REQ_WRITE);
    assign acc_wr    = (w.req_type == REQ_WRITE);

    always_comb begin
        n_tick  = r_tick;
        n_level = r_level;
        n_phase = r_phase;
        n_start = r_start;
        n_addr  = r_addr;
        n_rnw   = r_rnw;
        n_pay   = r_pay;
        n_shift = r_shift;
        n_rx    = r_rx;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_ack   = r_ack;
        n_eh    = r_eh;
        n_ed    = r_ed;
        n_irq   = r_irq;
        n_ie    = r_ie;
        n_rst   = r_rst;
        n_dir   = r_dir;
        chg     = 1'b0;
        lat     = 1'b0;
        rd      = '0;

        // Bit clock: SCL toggles at the end of each half period. SDA moves
        // at the setup point while SCL is low and is sampled while SCL is high.
        if (r_div != '0) begin
            if (r_phase == PH_IDLE) begin
                n_tick  = '0;
                n_level = 1'b1;
            end else if (r_tick == r_div - CFG_W'(1)) begin
                n_tick  = '0;
                n_level = !r_level;
            end else begin
                n_tick = r_tick + CFG_W'(1);
                if (r_tick == r_setup) begin
                    chg = !r_level;
                    lat = r_level;
                end
            end
        end
        if (chg) begin
            n_shift = {r_shift[SHIFT_W-2:0], 1'b1};
        end
        if (lat) begin
            n_rx = {r_rx[6:0], w.sda_in};
        end

        unique case (r_phase)
            PH_IDLE: begin
                n_start = 1'b0;
                n_shift = '1;
                n_dir   = 1'b0;
                if (r_start) begin
                    // Start bit, address, R/W, ack slot and the first data byte.
                    n_shift = {1'b0, r_addr, r_rnw, 1'b0, r_pay[7:0], 1'b1};
                    n_pay   = {8'd0, r_pay[DATA_W-1:8]};
                    n_phase = PH_START;
                end
            end
            PH_START: begin
                if (chg) begin
                    n_bit   = BIT_START;
                    n_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (chg) begin
                    if (r_bit == '0) begin
                        n_dir   = 1'b1;
                        n_phase = PH_ACK_HEADER;
                    end else begin
                        n_bit = r_bit - 3'd1;
                    end
                end
            end
            PH_ACK_HEADER: begin
                if (lat) begin
                    n_ack = w.sda_in;
                end
                if (chg) begin
                    n_dir = 1'b0;
                    if (!r_ack) begin
                        n_bit = BIT_START;
                        if (r_rnw) begin
                            n_phase = PH_RX;
                            n_dir   = 1'b1;
                        end else begin
                            n_phase = PH_TX;
                        end
                    end else begin
                        n_eh    = 1'b1;
                        n_phase = PH_STOP;
                    end
                end
            end
            PH_RX: begin
                if (chg) begin
                    if (r_bit == '0) begin
                        n_dir  = 1'b0;
                        n_byte = r_byte - 4'd1;
                        n_pay  = {r_pay[DATA_W-9:0], r_rx};
                        // Drive ACK low while the byte count is two or more; a count of one or zero NACKs.
                        n_shift = (r_byte[3:1] != '0) ? '0 : '1;
                        n_phase = PH_ACK_RX;
                    end else begin
                        n_bit = r_bit - 3'd1;
                    end
                end
            end
            PH_ACK_RX: begin
                if (chg) begin
                    if (r_byte == '0) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_bit   = BIT_START;
                        n_dir   = 1'b1;
                        n_phase = PH_RX;
                    end
                end
            end
            PH_TX: begin
                if (chg) begin
                    if (r_bit == '0) begin
                        n_shift = '0;
                        n_dir   = 1'b1;
                        n_phase = PH_WAIT_ACK_TX;
                        if (r_byte != '0) begin
                            n_byte = r_byte - 4'd1;
                        end
                    end else begin
                        n_bit = r_bit - 3'd1;
                    end
                end
            end
            PH_WAIT_ACK_TX: begin
                if (lat) begin
                    n_ack = w.sda_in;
                end
                if (chg) begin
                    n_dir = 1'b0;
                    if (r_ack || (r_byte == '0)) begin
                        n_ed    = r_ack;
                        n_phase = PH_STOP;
                    end else begin
                        n_bit   = BIT_START;
                        n_shift = {r_pay[7:0], TX_FILL};
                        n_pay   = {8'd0, r_pay[DATA_W-1:8]};
                        n_phase = PH_TX;
                    end
                end
            end
            PH_STOP: begin
                if (lat) begin
                    n_shift = '1;
                    n_phase = PH_IDLE;
                    n_irq   = r_ie;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // Register access, decoded against the state before this tick.
        if (acc_valid) begin
            unique case (w.reg_index)
                REG_DIVIDER: begin
                    rd = {16'd0, r_div};
                end
                REG_STATUS: begin
                    rd = {14'd0, r_rst, r_rst, 2'b00, r_irq, r_ie, 1'b0,
                          r_ed, r_eh, w.sda_in, 4'd0, r_phase};
                    n_irq = 1'b0;
                    if (acc_wr) begin
                        n_eh  = 1'b0;
                        n_ed  = 1'b0;
                        n_ie  = w.write_data[12];
                        n_irq = w.write_data[13];
                        if (w.write_data[16]) begin
                            n_rst = 1'b1;
                        end else if (w.write_data[17]) begin
                            n_rst = 1'b0;
                        end
                    end
                end
                REG_ADDRESS: begin
                    rd = {r_rnw, 11'd0, r_byte, 9'd0, r_addr};
                    if (acc_wr) begin
                        n_rnw   = w.write_data[31];
                        n_byte  = w.write_data[19:16];
                        n_addr  = w.write_data[6:0];
                        n_start = 1'b1;
                    end
                end
                REG_PAYLOAD: begin
                    rd = r_pay;
                    if (acc_wr) begin
                        n_pay = w.write_data;
                    end
                end
                default: begin
                    rd = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= '0;
            r_setup <= '0;
            r_tick  <= '0;
            r_level <= 1'b1;
            r_phase <= PH_IDLE;
            r_start <= 1'b0;
            r_addr  <= '0;
            r_rnw   <= 1'b0;
            r_pay   <= '0;
            r_shift <= '1;
            r_rx    <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_ack   <= 1'b0;
            r_eh    <= 1'b0;
            r_ed    <= 1'b0;
            r_irq   <= 1'b0;
            r_ie    <= 1'b0;
            r_rst   <= 1'b0;
            r_dir   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_level <= n_level;
                r_phase <= n_phase;
                r_start <= n_start;
                r_addr  <= n_addr;
                r_rnw   <= n_rnw;
                r_pay   <= n_pay;
                r_shift <= n_shift;
                r_rx    <= n_rx;
                r_bit   <= n_bit;
                r_byte  <= n_byte;
                r_ack   <= n_ack;
                r_eh    <= n_eh;
                r_ed    <= n_ed;
                r_irq   <= n_irq;
                r_ie    <= n_ie;
                r_rst   <= n_rst;
                r_dir   <= n_dir;
            end
            // A configuration write restarts the half-period counter.
            if (i_cfg_we) begin
                r_tick <= '0;
                if (i_cfg_idx == CFG_DIVIDER) begin
                    r_div <= i_cfg_wdata;
                end else if (i_cfg_idx == CFG_SETUP) begin
                    r_setup <= i_cfg_wdata;
                end
            end else if (in_acc) begin
                r_tick <= n_tick;
            end
        end
    end

    // Output register: filled on every accepted word, drained by the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.answered         <= acc_valid;
            r_out.read_data        <= rd;
            r_out.scl_out          <= n_level;
            r_out.sda_out          <= n_shift[SHIFT_W-1];
            r_out.sda_is_input     <= n_dir;
            r_out.irq_out          <= n_irq;
            r_out.device_reset_out <= n_rst;
        end
    end

`ifndef SYNTHESIS
    a_idle_scl_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_phase == PH_IDLE) && (r_div != '0)) |=> r_level)
        else $error("SCL not high after an idle tick");

    a_idle_sda_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_phase == PH_IDLE)) |=> !r_dir)
        else $error("SDA released after an idle tick");

    a_start_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_phase == PH_IDLE) && !(acc_wr && (w.reg_index == REG_ADDRESS)))
        |=> !r_start)
        else $error("start request not consumed in idle");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted word produced no result");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/i2c_master_controller_tb.sv
// Self-checking testbench of the I2C master controller: directed table, then random traffic.
`default_nettype none

// The block advances one bus tick for every word accepted on its input channel
// and answers every word with exactly one result word. The testbench keeps its
// own model of the bus machine and register file. The model is stepped once for
// every word that is sent, and the result it predicts is queued. The monitor
// compares each result word that is taken, field by field, with the oldest word
// in that queue.
//
// The run has three parts:
//   1. A short directed table, run with the divider and setup point left at
//      their reset values. Rows whose outcome is obvious (reset values, field
//      extremes, status bit handling) carry their expected word. The remaining
//      rows, which start a transfer and rewrite the address while it is held,
//      are checked against the model.
//   2. A list of divider and setup settings. Each one is written while no word
//      is in flight. The list includes the extremes, and settings under which
//      the bus clock is frozen or too slow to move.
//   3. Under each setting, random traffic. Most is well-formed transfers: an
//      optional status write, a payload write and an address write, then
//      mostly plain ticks until the machine is idle. While the master waits
//      for an ACK, SDA is mostly driven low, so that transfers get past the
//      header. The rest is noise over every request type and all indices.
//
// The sender and the receiver stall at random. The sender first idles with a
// chance of 23 in a hundred and the receiver of 76, then the other way round,
// and last neither of them idles.
module i2c_master_controller_tb;
    import i2cm_pkg::*;

    // Request code that the block must treat as no access.
    localparam logic [1:0] REQ_RESERVED = 2'd3;
    // Highest register index. It is not decoded.
    localparam logic [INDEX_W-1:0] REG_UNUSED_TOP = 10'h3FF;

    // Cycles without any accepted word before the run is declared hung. The
    // slowest receiver stall is far shorter than this.
    localparam int STALL_LIMIT  = 4000;
    // Margin after the last result is back, before registers are rewritten or the
    // run ends.
    localparam int DRAIN_CYCLES = 4;

    // Item counts at which the idle pattern switches.
    localparam int SWAP_AT  = 440;
    localparam int STEADY_AT = 860;

    // A directed row. When typed is set, rd, irq and rst give the expected word.
    // Such a row is expected to leave the bus idle, with SCL and SDA high and SDA
    // driven.
    typedef struct packed {
        logic [1:0]         req;
        logic [INDEX_W-1:0] idx;
        logic [DATA_W-1:0]  wd;
        logic               sda;
        logic               typed;
        logic [DATA_W-1:0]  rd;
        logic               irq;
        logic               rst;
    } t_dir_row;

    localparam int DIR_N = 25;
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        // Reads right after reset.
        '{REQ_READ,     REG_DIVIDER,    32'h0,         1'b0, 1'b1, 32'h0,         1'b0, 1'b0},
        '{REQ_READ,     REG_STATUS,     32'h0,         1'b1, 1'b1, 32'h0000_0100, 1'b0, 1'b0},
        '{REQ_READ,     REG_ADDRESS,    32'h0,         1'b0, 1'b1, 32'h0,         1'b0, 1'b0},
        '{REQ_READ,     REG_PAYLOAD,    32'h0,         1'b0, 1'b1, 32'h0,         1'b0, 1'b0},
        '{REQ_READ,     REG_UNUSED_TOP, 32'h0,         1'b1, 1'b1, 32'h0,         1'b0, 1'b0},
        // The reserved request code and a plain tick are not answered.
        '{REQ_RESERVED, REG_STATUS,     32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0,         1'b0, 1'b0},
        '{REQ_NONE,     REG_PAYLOAD,    32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0,         1'b0, 1'b0},
        // The divider is read only from the register side.
        '{REQ_WRITE,    REG_DIVIDER,    32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0,         1'b0, 1'b0},
        '{REQ_READ,     REG_DIVIDER,    32'h0,         1'b0, 1'b1, 32'h0,         1'b0, 1'b0},
        // Payload extremes, and a write to an unused index that must be lost.
        '{REQ_WRITE,    REG_PAYLOAD,    32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0,         1'b0, 1'b0},
        '{REQ_READ,     REG_PAYLOAD,    32'h0,         1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0},
        '{REQ_WRITE,    REG_PAYLOAD,    32'h0,         1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0},
        '{REQ_WRITE,    REG_UNUSED_TOP, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0,         1'b0, 1'b0},
        '{REQ_READ,     REG_PAYLOAD,    32'h0,         1'b0, 1'b1, 32'h0,         1'b0, 1'b0},
        // Status: set enable, pending and device reset. Any access then clears
        // pending. Bit 17 alone clears the reset, and bit 16 wins over bit 17.
        '{REQ_WRITE,    REG_STATUS,     32'h0001_3000, 1'b0, 1'b1, 32'h0,         1'b1, 1'b1},
        '{REQ_READ,     REG_STATUS,     32'h0,         1'b0, 1'b1, 32'h0003_3000, 1'b0, 1'b1},
        '{REQ_WRITE,    REG_STATUS,     32'h0002_0000, 1'b0, 1'b1, 32'h0003_1000, 1'b0, 1'b0},
        '{REQ_WRITE,    REG_STATUS,     32'h0003_0000, 1'b1, 1'b1, 32'h0000_0100, 1'b0, 1'b1},
        '{REQ_WRITE,    REG_STATUS,     32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0003_0100, 1'b1, 1'b1},
        '{REQ_WRITE,    REG_STATUS,     32'h0,         1'b0, 1'b1, 32'h0003_3000, 1'b0, 1'b1},
        // Start a write transfer. With the divider at zero it stays in the start
        // phase. Then rewrite the address while it is held there.
        '{REQ_WRITE,    REG_PAYLOAD,    32'h0000_00A5, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{REQ_WRITE,    REG_ADDRESS,    32'h0001_002A, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{REQ_READ,     REG_STATUS,     32'h0,         1'b1, 1'b0, 32'h0,         1'b0, 1'b0},
        '{REQ_WRITE,    REG_ADDRESS,    32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{REQ_READ,     REG_ADDRESS,    32'h0,         1'b0, 1'b0, 32'h0,         1'b0, 1'b0}
    };

    // Divider and setup settings, with the number of random ticks run under
    // each one. Under some of them (a zero divider, a divider of 65535, a
    // setup point that is never reached) the bus does not move.
    localparam int N_SET = 8;
    localparam logic [CFG_W-1:0] SET_DIV   [N_SET] = '{16'd2, 16'd3, 16'd65535, 16'd5,
                                                       16'd2, 16'd0, 16'd4, 16'd3};
    localparam logic [CFG_W-1:0] SET_SETUP [N_SET] = '{16'd0, 16'd1, 16'd65535, 16'd3,
                                                       16'd0, 16'd0, 16'd0, 16'd1};
    localparam int SET_TICKS [N_SET] = '{250, 200, 60, 200, 200, 60, 150, 130};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_wdata;

    i2cm_in_if  in_if ();
    i2cm_out_if out_if ();

    i2c_master_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if.sink),
        .o_out       (out_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model of the bus machine and register file. The initial values are the
    // state after reset.
    logic [CFG_W-1:0]   bus_div   = '0;
    logic [CFG_W-1:0]   bus_setup = '0;
    logic [15:0]        bus_tick  = '0;
    logic               bus_level = 1'b1;
    t_phase             bus_phase = PH_IDLE;
    logic               bus_start = 1'b0;
    logic [6:0]         bus_addr  = '0;
    logic               bus_rnw   = 1'b0;
    logic [DATA_W-1:0]  bus_pay   = '0;
    logic [SHIFT_W-1:0] bus_shift = '1;
    logic [7:0]         bus_rx    = '0;
    logic [2:0]         bus_bit   = '0;
    logic [3:0]         bus_byte  = '0;
    logic               bus_ack   = 1'b0;
    logic               bus_eh    = 1'b0;
    logic               bus_ed    = 1'b0;
    logic               bus_irq   = 1'b0;
    logic               bus_ie    = 1'b0;
    logic               bus_rst   = 1'b0;
    logic               bus_dir   = 1'b0;

    t_out_word tick_outputs_q [$];

    int src_gap = 23;
    int snk_gap = 76;
    int items_sent = 0;
    int words_checked = 0;
    int mismatches = 0;
    int transfers = 0;
    int quiet_cycles = 0;
    t_out_word mon_exp;

    function automatic t_in_word mk_word(input logic [1:0] req, input logic [INDEX_W-1:0] idx,
                                         input logic [DATA_W-1:0] wd, input logic sda);
        t_in_word w;
        begin
            w.req_type   = req;
            w.reg_index  = idx;
            w.write_data = wd;
            w.sda_in     = sda;
            return w;
        end
    endfunction

    // Advances the bus model by one tick and returns the word the block should
    // answer with.
    function automatic t_out_word advance_bus(input t_in_word w);
        t_out_word          r;
        logic               acc, wr, chg, lat;
        logic [DATA_W-1:0]  rd, wd;
        logic [15:0]        n_tick;
        logic               n_level, n_start, n_rnw, n_ack, n_eh, n_ed;
        logic               n_irq, n_ie, n_rst, n_dir;
        t_phase             n_phase;
        logic [6:0]         n_addr;
        logic [DATA_W-1:0]  n_pay;
        logic [SHIFT_W-1:0] n_shift;
        logic [7:0]         n_rx;
        logic [2:0]         n_bit;
        logic [3:0]         n_byte;
        begin
            acc = (w.req_type == REQ_READ) || (w.req_type == REQ_WRITE);
            wr  = (w.req_type == REQ_WRITE);
            wd  = w.write_data;
            chg = 1'b0;
            lat = 1'b0;
            rd  = '0;
            n_tick = bus_tick;   n_level = bus_level; n_phase = bus_phase;
            n_start = bus_start; n_addr = bus_addr;   n_rnw = bus_rnw;
            n_pay = bus_pay;     n_shift = bus_shift; n_rx = bus_rx;
            n_bit = bus_bit;     n_byte = bus_byte;   n_ack = bus_ack;
            n_eh = bus_eh;       n_ed = bus_ed;       n_irq = bus_irq;
            n_ie = bus_ie;       n_rst = bus_rst;     n_dir = bus_dir;

            // SDA moves at the setup point of a low half period and is sampled
            // at the setup point of a high half period.
            if (bus_div != '0) begin
                if (bus_phase == PH_IDLE) begin
                    n_tick  = '0;
                    n_level = 1'b1;
                end else if (bus_tick == bus_div - 16'd1) begin
                    n_tick  = '0;
                    n_level = ~bus_level;
                end else begin
                    n_tick = bus_tick + 16'd1;
                    if (bus_tick == bus_setup) begin
                        chg = ~bus_level;
                        lat = bus_level;
                    end
                end
            end
            if (chg) n_shift = {bus_shift[SHIFT_W-2:0], 1'b1};
            if (lat) n_rx = {bus_rx[6:0], w.sda_in};

            case (bus_phase)
                PH_IDLE: begin
                    n_start = 1'b0;
                    n_shift = '1;
                    n_dir   = 1'b0;
                    if (bus_start) begin
                        // Start bit low, then address, R/W and the first byte.
                        n_shift = {1'b0, bus_addr, bus_rnw, 1'b0, bus_pay[7:0], 1'b1};
                        n_pay   = bus_pay >> 8;
                        n_phase = PH_START;
                    end
                end
                PH_START: begin
                    if (chg) begin
                        n_bit   = BIT_START;
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (chg) begin
                        if (bus_bit == '0) begin
                            n_dir   = 1'b1;
                            n_phase = PH_ACK_HEADER;
                        end else begin
                            n_bit = bus_bit - 3'd1;
                        end
                    end
                end
                PH_ACK_HEADER: begin
                    if (lat) n_ack = w.sda_in;
                    if (chg) begin
                        n_dir = 1'b0;
                        if (!bus_ack) begin
                            n_bit = BIT_START;
                            if (bus_rnw) begin
                                n_phase = PH_RX;
                                n_dir   = 1'b1;
                            end else begin
                                n_phase = PH_TX;
                            end
                        end else begin
                            n_eh    = 1'b1;
                            n_phase = PH_STOP;
                        end
                    end
                end
                PH_RX: begin
                    if (chg) begin
                        if (bus_bit == '0) begin
                            // ACK while the count is two or more, else NACK. A zero count
                            // wraps to fifteen, so reception goes on after a NACK.
                            n_dir   = 1'b0;
                            n_byte  = bus_byte - 4'd1;
                            n_pay   = {bus_pay[DATA_W-9:0], bus_rx};
                            n_shift = (bus_byte[3:1] != '0) ? '0 : '1;
                            n_phase = PH_ACK_RX;
                        end else begin
                            n_bit = bus_bit - 3'd1;
                        end
                    end
                end
                PH_ACK_RX: begin
                    if (chg) begin
                        if (bus_byte == '0) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_bit   = BIT_START;
                            n_dir   = 1'b1;
                            n_phase = PH_RX;
                        end
                    end
                end
                PH_TX: begin
                    if (chg) begin
                        if (bus_bit == '0) begin
                            n_shift = '0;
                            n_dir   = 1'b1;
                            n_phase = PH_WAIT_ACK_TX;
                            if (bus_byte != '0) n_byte = bus_byte - 4'd1;
                        end else begin
                            n_bit = bus_bit - 3'd1;
                        end
                    end
                end
                PH_WAIT_ACK_TX: begin
                    if (lat) n_ack = w.sda_in;
                    if (chg) begin
                        n_dir = 1'b0;
                        if (bus_ack || bus_byte == '0) begin
                            n_ed    = bus_ack;
                            n_phase = PH_STOP;
                        end else begin
                            n_bit   = BIT_START;
                            n_shift = {bus_pay[7:0], TX_FILL};
                            n_pay   = bus_pay >> 8;
                            n_phase = PH_TX;
                        end
                    end
                end
                PH_STOP: begin
                    if (lat) begin
                        n_shift = '1;
                        n_phase = PH_IDLE;
                        n_irq   = bus_ie;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // The register access sees the state from before this tick. Its
            // writes take priority over the bus machine.
            if (acc) begin
                case (w.reg_index)
                    REG_DIVIDER: begin
                        rd[CFG_W-1:0] = bus_div;
                    end
                    REG_STATUS: begin
                        rd[3:0] = bus_phase;
                        rd[8]   = w.sda_in;
                        rd[9]   = bus_eh;
                        rd[10]  = bus_ed;
                        rd[12]  = bus_ie;
                        rd[13]  = bus_irq;
                        rd[16]  = bus_rst;
                        rd[17]  = bus_rst;
                        n_irq   = 1'b0;
                        if (wr) begin
                            n_eh  = 1'b0;
                            n_ed  = 1'b0;
                            n_ie  = wd[12];
                            n_irq = wd[13];
                            if (wd[16]) n_rst = 1'b1;
                            else if (wd[17]) n_rst = 1'b0;
                        end
                    end
                    REG_ADDRESS: begin
                        rd[31]    = bus_rnw;
                        rd[19:16] = bus_byte;
                        rd[6:0]   = bus_addr;
                        if (wr) begin
                            n_rnw   = wd[31];
                            n_byte  = wd[19:16];
                            n_addr  = wd[6:0];
                            n_start = 1'b1;
                        end
                    end
                    REG_PAYLOAD: begin
                        rd = bus_pay;
                        if (wr) n_pay = wd;
                    end
                    default: begin
                    end
                endcase
            end

            bus_tick = n_tick;   bus_level = n_level; bus_phase = n_phase;
            bus_start = n_start; bus_addr = n_addr;   bus_rnw = n_rnw;
            bus_pay = n_pay;     bus_shift = n_shift; bus_rx = n_rx;
            bus_bit = n_bit;     bus_byte = n_byte;   bus_ack = n_ack;
            bus_eh = n_eh;       bus_ed = n_ed;       bus_irq = n_irq;
            bus_ie = n_ie;       bus_rst = n_rst;     bus_dir = n_dir;

            r.answered         = acc;
            r.read_data        = rd;
            r.scl_out          = bus_level;
            r.sda_out          = bus_shift[SHIFT_W-1];
            r.sda_is_input     = bus_dir;
            r.irq_out          = bus_irq;
            r.device_reset_out = bus_rst;
            return r;
        end
    endfunction

    // Offers one tick word and returns at the edge where it is taken. The model
    // is stepped for every word. A directed row with a typed expectation queues
    // that word in place of the predicted one.
    task automatic drive_tick(input t_in_word w, input bit typed, input t_out_word typed_out);
        t_out_word predicted;
        begin
            predicted = advance_bus(w);
            while (src_gap > 0 && $urandom_range(99) < src_gap) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
            in_if.data  <= w;
            in_if.valid <= 1'b1;
            tick_outputs_q.push_back(typed ? typed_out : predicted);
            items_sent++;
            do @(posedge i_clk); while (!in_if.ready);
        end
    endtask

    task automatic report_field(input string name, input logic [DATA_W-1:0] e,
                                input logic [DATA_W-1:0] a);
        begin
            if (e !== a) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
                mismatches++;
            end
        end
    endtask

    // The receiver drops ready at random, at the rate of the current pattern.
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_gap);
    end

    // Result monitor. Signals are read at the clock edge, before any
    // nonblocking update of that edge takes effect.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            words_checked++;
            if (tick_outputs_q.size() == 0) begin
                $display("%0t: result word with nothing expected, expected none, got %h",
                         $time, out_if.data);
                mismatches++;
            end else begin
                mon_exp = tick_outputs_q.pop_front();
                report_field("answered", 32'(mon_exp.answered), 32'(out_if.data.answered));
                report_field("read_data", mon_exp.read_data, out_if.data.read_data);
                report_field("scl_out", 32'(mon_exp.scl_out), 32'(out_if.data.scl_out));
                report_field("sda_out", 32'(mon_exp.sda_out), 32'(out_if.data.sda_out));
                report_field("sda_is_input", 32'(mon_exp.sda_is_input),
                             32'(out_if.data.sda_is_input));
                report_field("irq_out", 32'(mon_exp.irq_out), 32'(out_if.data.irq_out));
                report_field("device_reset_out", 32'(mon_exp.device_reset_out),
                             32'(out_if.data.device_reset_out));
            end
        end
    end

    // Watchdog. It counts cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, tick_outputs_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int            s, k, r, phase_end;
        t_dir_row      row;
        t_out_word     typed_out;
        t_in_word      w;
        logic [31:0]   wd;
        logic          sda_lvl;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_DIVIDER;
        i_cfg_wdata  <= '0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed table runs with the reset settings: divider and setup at zero.
        for (k = 0; k < DIR_N; k++) begin
            row = DIR_TAB[k];
            typed_out.answered         = (row.req == REQ_READ) || (row.req == REQ_WRITE);
            typed_out.read_data        = row.rd;
            typed_out.scl_out          = 1'b1;
            typed_out.sda_out          = 1'b1;
            typed_out.sda_is_input     = 1'b0;
            typed_out.irq_out          = row.irq;
            typed_out.device_reset_out = row.rst;
            drive_tick(mk_word(row.req, row.idx, row.wd, row.sda), row.typed, typed_out);
        end

        for (s = 0; s < N_SET; s++) begin
            // Settings change only after every result is back and the latency
            // has passed, so no word is in flight during the write.
            in_if.valid <= 1'b0;
            while (tick_outputs_q.size() != 0) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= CFG_DIVIDER;
            i_cfg_wdata <= SET_DIV[s];
            @(posedge i_clk);
            bus_div  = SET_DIV[s];
            bus_tick = '0;
            i_cfg_idx   <= CFG_SETUP;
            i_cfg_wdata <= SET_SETUP[s];
            @(posedge i_clk);
            bus_setup = SET_SETUP[s];
            bus_tick  = '0;
            i_cfg_we <= 1'b0;

            phase_end = items_sent + SET_TICKS[s];
            while (items_sent < phase_end) begin
                if (items_sent < SWAP_AT) begin
                    src_gap = 23;
                    snk_gap = 76;
                end else if (items_sent < STEADY_AT) begin
                    src_gap = 76;
                    snk_gap = 23;
                end else begin
                    src_gap = 0;
                    snk_gap = 0;
                end

                if ($urandom_range(99) < 80) begin
                    // A well-formed transfer, or the rest of one that is still
                    // in progress.
                    if (bus_phase == PH_IDLE && !bus_start) begin
                        transfers++;
                        if ($urandom_range(1) == 1) begin
                            drive_tick(mk_word(REQ_WRITE, REG_STATUS, $urandom(),
                                               1'($urandom_range(1))), 1'b0, '0);
                        end
                        drive_tick(mk_word(REQ_WRITE, REG_PAYLOAD, $urandom(),
                                           1'($urandom_range(1))), 1'b0, '0);
                        // Byte counts are mostly short. A few use the full range,
                        // zero included, which makes a receive run sixteen bytes.
                        wd = $urandom();
                        wd[19:16] = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                             : 4'($urandom_range(3));
                        drive_tick(mk_word(REQ_WRITE, REG_ADDRESS, wd,
                                           1'($urandom_range(1))), 1'b0, '0);
                    end
                    while ((bus_phase != PH_IDLE || bus_start) && items_sent < phase_end) begin
                        // The slave mostly ACKs, so transfers reach the data bytes.
                        if (bus_phase == PH_ACK_HEADER || bus_phase == PH_WAIT_ACK_TX) begin
                            sda_lvl = ($urandom_range(9) == 0);
                        end else begin
                            sda_lvl = 1'($urandom_range(1));
                        end
                        r = $urandom_range(99);
                        if (r < 88) begin
                            w = mk_word(REQ_NONE, 10'($urandom_range(1023)), $urandom(), sda_lvl);
                        end else if (r < 97) begin
                            w = mk_word(REQ_READ, 10'($urandom_range(3)), $urandom(), sda_lvl);
                        end else if (r < 99) begin
                            w = mk_word(REQ_WRITE, REG_PAYLOAD, $urandom(), sda_lvl);
                        end else begin
                            // Address write while the transfer runs. The start is held.
                            w = mk_word(REQ_WRITE, REG_ADDRESS, $urandom() & 32'h8003_007F,
                                        sda_lvl);
                        end
                        drive_tick(w, 1'b0, '0);
                    end
                end else begin
                    // Noise: any request code, mostly at decoded indices.
                    w = mk_word(2'($urandom_range(3)),
                                ($urandom_range(1) == 1) ? 10'($urandom_range(3))
                                                         : 10'($urandom_range(1023)),
                                $urandom(), 1'($urandom_range(1)));
                    drive_tick(w, 1'b0, '0);
                end
            end
        end

        in_if.valid <= 1'b0;
        while (tick_outputs_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d ticks (%0d directed) under %0d divider/setup settings, %0d transfers.",
                 items_sent, DIR_N, N_SET, transfers);
        $display("Checked %0d result words, %0d field mismatches.", words_checked, mismatches);
        if (mismatches == 0 && tick_outputs_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
sv/i2cm_pkg.sv
sv/i2cm_in_if.sv
sv/i2cm_out_if.sv
sv/i2c_master_controller.sv
tb/sv/i2c_master_controller_tb.sv
